// File: hdl/sls_pkg.sv
// Shared types, character constants and column limits for the string literal span scanner.
`default_nettype none

package sls_pkg;

    // Field widths of the character and result items.
    localparam int CH_W  = 21;
    localparam int COL_W = 16;

    // Columns saturate at this value.
    localparam logic [COL_W-1:0] COLUMN_LIMIT = 16'hFFFF;

    // Character codes that steer the scan.
    localparam logic [CH_W-1:0] CHAR_NUL    = 21'd0;
    localparam logic [CH_W-1:0] CHAR_LF     = 21'd10;
    localparam logic [CH_W-1:0] CHAR_SPACE  = 21'd32;
    localparam logic [CH_W-1:0] CHAR_DQUOTE = 21'd34;
    localparam logic [CH_W-1:0] CHAR_SQUOTE = 21'd39;
    localparam logic [CH_W-1:0] CHAR_BSLASH = 21'd92;

    // Low byte bound for whitespace between two merging literals.
    localparam logic [7:0] BLANK_LOW_BYTE = 8'd32;

    // Scan modes.
    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_INSIDE,
        MODE_ESCAPE,
        MODE_CLOSED
    } sls_mode_t;

    // Scanner state carried from one character to the next.
    typedef struct packed {
        sls_mode_t        mode;
        logic             quote_is_single;
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] open_column;
        logic [COL_W-1:0] close_column;
        logic             seen_nonblank;
        logic             starts_flag;
        logic             ends_flag;
    } sls_state_t;

    // Result of one character; has_result marks that an item is produced.
    typedef struct packed {
        logic             has_result;
        logic             span_valid;
        logic [COL_W-1:0] span_begin;
        logic [COL_W-1:0] span_end;
        logic             line_done;
        logic             line_starts_with_quote;
        logic             line_ends_after_close;
    } sls_result_t;

    localparam sls_state_t STATE_RESET = '{
        mode:            MODE_OUTSIDE,
        quote_is_single: 1'b0,
        column:          '0,
        open_column:     '0,
        close_column:    '0,
        seen_nonblank:   1'b0,
        starts_flag:     1'b0,
        ends_flag:       1'b0
    };

endpackage

`default_nettype wire

// File: hdl/sls_ch_if.sv
// Valid/ready channel that carries one character item.
`default_nettype none

interface sls_ch_if
    import sls_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

// File: hdl/sls_span_if.sv
// Valid/ready channel that carries one span and line result item.
`default_nettype none

interface sls_span_if
    import sls_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             span_valid;
    logic [COL_W-1:0] span_begin;
    logic [COL_W-1:0] span_end;
    logic             line_done;
    logic             line_starts_with_quote;
    logic             line_ends_after_close;

    modport source (
        output valid, output span_valid, output span_begin, output span_end,
        output line_done, output line_starts_with_quote, output line_ends_after_close,
        input ready
    );
    modport sink (
        input valid, input span_valid, input span_begin, input span_end,
        input line_done, input line_starts_with_quote, input line_ends_after_close,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/sls_step.sv
// Combinational scan step: next state and result for one character.
`default_nettype none

module sls_step
    import sls_pkg::*;
(
    input  sls_state_t        state,
    input  logic [CH_W-1:0]   ch,
    output sls_state_t        state_next,
    output sls_result_t       result
);

    logic            is_line_end;
    logic            is_quote;
    logic            is_blank_low;
    logic [CH_W-1:0] term;
    logic [COL_W-1:0] column_inc;

    // Character classes for the next-state and result blocks.
    assign is_line_end  = (ch == CHAR_NUL) || (ch == CHAR_LF);
    assign is_quote     = (ch == CHAR_DQUOTE) || (ch == CHAR_SQUOTE);
    assign is_blank_low = (ch[7:0] <= BLANK_LOW_BYTE);
    assign term         = state.quote_is_single ? CHAR_SQUOTE : CHAR_DQUOTE;
    assign column_inc   = (state.column >= COLUMN_LIMIT) ? COLUMN_LIMIT
                                                         : state.column + 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state;
        if (is_line_end)
        begin
            state_next = STATE_RESET;
        end
        else
        begin
            if (!state.seen_nonblank && (ch > CHAR_SPACE))
            begin
                state_next.seen_nonblank = 1'b1;
                state_next.starts_flag   = (ch == CHAR_DQUOTE);
            end
            case (state.mode)
                MODE_OUTSIDE:
                begin
                    if (is_quote)
                    begin
                        state_next.open_column     = state.column;
                        state_next.quote_is_single = (ch == CHAR_SQUOTE);
                        state_next.mode            = MODE_INSIDE;
                    end
                end
                MODE_INSIDE:
                begin
                    if (ch == term)
                    begin
                        state_next.close_column = column_inc;
                        state_next.mode         = MODE_CLOSED;
                    end
                    else if (ch == CHAR_BSLASH)
                    begin
                        state_next.mode = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE:
                begin
                    state_next.mode = MODE_INSIDE;
                end
                MODE_CLOSED:
                begin
                    if (is_blank_low)
                    begin
                        state_next.mode = MODE_CLOSED;
                    end
                    else if (ch == term)
                    begin
                        state_next.mode = MODE_INSIDE;
                    end
                    else
                    begin
                        // The literal is finished and this character is rescanned outside.
                        state_next.ends_flag = 1'b0;
                        state_next.mode      = MODE_OUTSIDE;
                        if (is_quote)
                        begin
                            state_next.open_column     = state.column;
                            state_next.quote_is_single = (ch == CHAR_SQUOTE);
                            state_next.mode            = MODE_INSIDE;
                        end
                    end
                end
                default:
                begin
                    state_next.mode = MODE_OUTSIDE;
                end
            endcase
            state_next.column = column_inc;
        end
    end

    // Result of this character.
    always_comb
    begin
        result = '0;
        if (is_line_end)
        begin
            result.has_result             = 1'b1;
            result.line_done              = 1'b1;
            result.line_starts_with_quote = state.starts_flag;
            result.line_ends_after_close  = state.ends_flag || (state.mode == MODE_CLOSED);
            case (state.mode)
                MODE_INSIDE, MODE_ESCAPE:
                begin
                    // An unclosed literal runs to the line end.
                    result.span_valid = !state.quote_is_single;
                    result.span_begin = state.quote_is_single ? '0 : state.open_column;
                    result.span_end   = state.quote_is_single ? '0 : state.column;
                end
                MODE_CLOSED:
                begin
                    result.span_valid = !state.quote_is_single;
                    result.span_begin = state.quote_is_single ? '0 : state.open_column;
                    result.span_end   = state.quote_is_single ? '0 : state.close_column;
                end
                default:
                begin
                    result.span_valid = 1'b0;
                end
            endcase
        end
        else if ((state.mode == MODE_CLOSED) && !is_blank_low && (ch != term)
                 && !state.quote_is_single)
        begin
            result.has_result = 1'b1;
            result.span_valid = 1'b1;
            result.span_begin = state.open_column;
            result.span_end   = state.close_column;
        end
    end

endmodule

`default_nettype wire

// File: hdl/string_literal_span_scanner.sv
// Output: a result item appears on spans in the cycle after its character is taken.
// Throughput: one character item per cycle; the single output register stalls the input
// only while it holds an item that spans has not taken.
// Reset: rst_n clears the scan state to outside any literal at column zero and empties
// the output register; the scan state also returns to reset at every line end.
// Top level of the string literal span scanner.
`default_nettype none

module string_literal_span_scanner
    import sls_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    sls_ch_if.sink      chars,
    sls_span_if.source  spans
);

    sls_state_t  state_reg;
    sls_state_t  state_next;
    sls_result_t step_result;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             span_valid_reg;
    logic [COL_W-1:0] span_begin_reg;
    logic [COL_W-1:0] span_end_reg;
    logic             line_done_reg;
    logic             starts_reg;
    logic             ends_reg;

    logic accept;
    logic accept_line_end;

    // The input is taken whenever the output register is empty or being drained.
    assign chars.ready     = !out_valid_reg || spans.ready;
    assign accept          = chars.valid && chars.ready;
    assign accept_line_end = accept && ((chars.ch == CHAR_NUL) || (chars.ch == CHAR_LF));

    sls_step u_step (
        .state      (state_reg),
        .ch         (chars.ch),
        .state_next (state_next),
        .result     (step_result)
    );

    // Scan state advances on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        if (accept && step_result.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (spans.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload is loaded with each produced item.
    always_ff @(posedge clk)
    begin
        if (accept && step_result.has_result)
        begin
            span_valid_reg <= step_result.span_valid;
            span_begin_reg <= step_result.span_begin;
            span_end_reg   <= step_result.span_end;
            line_done_reg  <= step_result.line_done;
            starts_reg     <= step_result.line_starts_with_quote;
            ends_reg       <= step_result.line_ends_after_close;
        end
    end

    assign spans.valid                  = out_valid_reg;
    assign spans.span_valid             = span_valid_reg;
    assign spans.span_begin             = span_begin_reg;
    assign spans.span_end               = span_end_reg;
    assign spans.line_done              = line_done_reg;
    assign spans.line_starts_with_quote = starts_reg;
    assign spans.line_ends_after_close  = ends_reg;

    // A line end always yields a line result in the next cycle.
    a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_line_end |=> spans.valid && spans.line_done)
        else $error("line end did not produce a line result");

    // A line end returns the scan to the start of a fresh line.
    a_line_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        accept_line_end |=> (state_reg.column == '0) && (state_reg.mode == MODE_OUTSIDE)
                            && !state_reg.seen_nonblank)
        else $error("scan state not cleared after line end");

    // A reported span never ends before it begins.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        spans.valid && spans.span_valid |-> spans.span_begin <= spans.span_end)
        else $error("span end lies before span begin");

    // An empty output register never stalls the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> chars.ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// File: tb/tb_string_literal_span_scanner.sv
// Self-checking testbench for the string literal span scanner: directed table and random text.
`timescale 1ns / 100ps

module tb_string_literal_span_scanner;
    import sls_pkg::*;

    // Cycles with no item accepted on either channel before the run is abandoned.
    localparam int STALL_LIMIT   = 2000;
    // Cycles allowed after the last expected item for stray items to show up.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_CHARS  = 560;
    localparam int REPORT_LIMIT  = 10;

    // One row of the directed table; want is only used where typed is set.
    typedef struct {
        logic [CH_W-1:0] ch;
        bit              typed;
        sls_result_t     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sls_ch_if   chars_if ();
    sls_span_if spans_if ();

    string_literal_span_scanner dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .spans (spans_if)
    );

    // Predicted scanner state, the result items still owed by the block and the directed table.
    sls_state_t  scan_state;
    sls_result_t expected_spans[$];
    stim_row_t   dir_tab[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_cycles;
    int unsigned fail_count;
    int unsigned chars_sent;
    int unsigned lines_sent;
    int unsigned results_checked;
    int unsigned spans_checked;

    always #1 clk = ~clk;

    // Column step that holds at the saturation limit.
    function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] col);
        return (col == COLUMN_LIMIT) ? col : col + 1'b1;
    endfunction

    // A double or single quote opens a literal at the current column.
    function automatic void open_quote(input logic [CH_W-1:0] c);
        if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
            scan_state.open_column     = scan_state.column;
            scan_state.quote_is_single = (c == CHAR_SQUOTE);
            scan_state.mode            = MODE_INSIDE;
        end
    endfunction

    // Advances the predicted state by one character and returns the item it causes.
    function automatic sls_result_t scan_char(input logic [CH_W-1:0] c);
        sls_result_t     r;
        logic [CH_W-1:0] term;
        r    = '0;
        term = scan_state.quote_is_single ? CHAR_SQUOTE : CHAR_DQUOTE;

        // Line end: flush any pending literal, report the line flags and start afresh.
        if (c == CHAR_NUL || c == CHAR_LF) begin
            case (scan_state.mode)
                MODE_INSIDE, MODE_ESCAPE: begin
                    if (!scan_state.quote_is_single) begin
                        r.span_valid = 1'b1;
                        r.span_begin = scan_state.open_column;
                        r.span_end   = scan_state.column;
                    end
                end
                MODE_CLOSED: begin
                    scan_state.ends_flag = 1'b1;
                    if (!scan_state.quote_is_single) begin
                        r.span_valid = 1'b1;
                        r.span_begin = scan_state.open_column;
                        r.span_end   = scan_state.close_column;
                    end
                end
                default: ;
            endcase
            r.has_result             = 1'b1;
            r.line_done              = 1'b1;
            r.line_starts_with_quote = scan_state.starts_flag;
            r.line_ends_after_close  = scan_state.ends_flag;
            scan_state               = STATE_RESET;
            return r;
        end

        // The first character above a space decides whether the line opens with a double quote.
        if (!scan_state.seen_nonblank && c > CHAR_SPACE) begin
            scan_state.seen_nonblank = 1'b1;
            scan_state.starts_flag   = (c == CHAR_DQUOTE);
        end

        case (scan_state.mode)
            MODE_OUTSIDE: open_quote(c);
            MODE_INSIDE: begin
                if (c == term) begin
                    scan_state.close_column = next_col(scan_state.column);
                    scan_state.mode         = MODE_CLOSED;
                end else if (c == CHAR_BSLASH) begin
                    scan_state.mode = MODE_ESCAPE;
                end
            end
            MODE_ESCAPE: scan_state.mode = MODE_INSIDE;
            default: begin
                // Blanks after a close keep the literal open for a merge.
                if (c[7:0] > BLANK_LOW_BYTE) begin
                    if (c == term) begin
                        scan_state.mode = MODE_INSIDE;
                    end else begin
                        scan_state.ends_flag = 1'b0;
                        if (!scan_state.quote_is_single) begin
                            r.span_valid = 1'b1;
                            r.span_begin = scan_state.open_column;
                            r.span_end   = scan_state.close_column;
                        end
                        scan_state.mode = MODE_OUTSIDE;
                        open_quote(c);
                    end
                end
            end
        endcase

        scan_state.column = next_col(scan_state.column);
        r.has_result      = r.span_valid;
        return r;
    endfunction

    // Random text, weighted towards quotes, escapes, blanks and line ends.
    function automatic logic [CH_W-1:0] pick_char();
        logic [CH_W-1:0] c;
        int unsigned     roll;
        roll = $urandom_range(99);
        if (roll < 22) begin
            c = CHAR_DQUOTE;
        end else if (roll < 30) begin
            c = CHAR_SQUOTE;
        end else if (roll < 37) begin
            c = CHAR_BSLASH;
        end else if (roll < 55) begin
            // Blank by its low byte, sometimes with high bits set.
            c[7:0]  = 8'($urandom_range(32));
            c[20:8] = ($urandom_range(3) == 0) ? 13'($urandom) : 13'd0;
            if (c == CHAR_NUL || c == CHAR_LF)
                c = CHAR_SPACE;
        end else if (roll < 60) begin
            c = $urandom_range(1) ? CHAR_LF : CHAR_NUL;
        end else if (roll < 66) begin
            c = 21'($urandom);
        end else begin
            c = 21'($urandom_range(126, 33));
        end
        return c;
    endfunction

    function automatic void add_row(input logic [CH_W-1:0] c, input bit typed = 1'b0,
                                    input logic sv = 1'b0, input logic [COL_W-1:0] sb = '0,
                                    input logic [COL_W-1:0] se = '0, input logic ld = 1'b0,
                                    input logic sq = 1'b0, input logic ea = 1'b0);
        stim_row_t row;
        row.ch    = c;
        row.typed = typed;
        row.want  = '{has_result: typed, span_valid: sv, span_begin: sb, span_end: se,
                      line_done: ld, line_starts_with_quote: sq, line_ends_after_close: ea};
        dir_tab.push_back(row);
    endfunction

    // Offers one character item, waits for it to be taken and records what it should cause.
    task automatic send_char(input logic [CH_W-1:0] c, input bit typed, input sls_result_t want);
        sls_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.ch    <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        res = scan_char(c);
        if (typed)
            res = want;
        if (res.has_result)
            expected_spans.push_back(res);
        chars_sent++;
        if (c == CHAR_NUL || c == CHAR_LF)
            lines_sent++;
    endtask

    // Result side: random back-pressure and comparison with the oldest expected item.
    always @(posedge clk) begin : result_side
        sls_result_t got;
        sls_result_t want;
        if (spans_if.valid && spans_if.ready) begin
            got = '{has_result: 1'b1, span_valid: spans_if.span_valid,
                    span_begin: spans_if.span_begin, span_end: spans_if.span_end,
                    line_done: spans_if.line_done,
                    line_starts_with_quote: spans_if.line_starts_with_quote,
                    line_ends_after_close: spans_if.line_ends_after_close};
            if (expected_spans.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected item span=%0b %0d..%0d line_done=%0b",
                             $realtime, got.span_valid, got.span_begin, got.span_end,
                             got.line_done);
            end else begin
                want = expected_spans.pop_front();
                results_checked++;
                if (got.span_valid)
                    spans_checked++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch, expected span=%0b %0d..%0d done=%0b sq=%0b ea=%0b",
                                 $realtime, want.span_valid, want.span_begin, want.span_end,
                                 want.line_done, want.line_starts_with_quote,
                                 want.line_ends_after_close);
                        $display("%0t:           actual span=%0b %0d..%0d done=%0b sq=%0b ea=%0b",
                                 $realtime, got.span_valid, got.span_begin, got.span_end,
                                 got.line_done, got.line_starts_with_quote,
                                 got.line_ends_after_close);
                    end
                end
            end
        end
        spans_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge clk) begin
        if ((chars_if.valid && chars_if.ready) || (spans_if.valid && spans_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        chars_if.valid  = 1'b0;
        chars_if.ch     = '0;
        spans_if.ready  = 1'b0;
        stall_cycles    = 0;
        fail_count      = 0;
        chars_sent      = 0;
        lines_sent      = 0;
        results_checked = 0;
        spans_checked   = 0;
        send_idle_pct   = 19;
        recv_idle_pct   = 47;
        scan_state      = STATE_RESET;

        // An empty line straight after reset.
        add_row(CHAR_LF, 1'b1, 1'b0, 0, 0, 1'b1, 1'b0, 1'b0);
        // A closed empty double literal runs into the line end.
        add_row(CHAR_DQUOTE);
        add_row(CHAR_DQUOTE);
        add_row(CHAR_LF, 1'b1, 1'b1, 0, 2, 1'b1, 1'b1, 1'b1);
        // Leading blank, merged single literals, escaped quote, merged doubles, unclosed end.
        add_row(CHAR_SPACE);
        add_row(CHAR_SQUOTE);
        add_row(21'd120);
        add_row(CHAR_SQUOTE);
        add_row(21'h000100);
        add_row(CHAR_SQUOTE);
        add_row(CHAR_SQUOTE);
        add_row(CHAR_DQUOTE);
        add_row(CHAR_BSLASH);
        add_row(CHAR_DQUOTE);
        add_row(CHAR_DQUOTE);
        add_row(21'h00010A);
        add_row(CHAR_DQUOTE);
        add_row(21'h1FFFFF);
        add_row(CHAR_NUL, 1'b1, 1'b1, 7, 14, 1'b1, 1'b0, 1'b0);
        // A close that is not followed by a merge reports the span mid-line.
        add_row(CHAR_DQUOTE);
        add_row(CHAR_DQUOTE);
        add_row(21'd120, 1'b1, 1'b1, 0, 2, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_LF, 1'b1, 1'b0, 0, 0, 1'b1, 1'b1, 1'b0);
        // A closed single literal sets the trailing flag but reports no span.
        add_row(CHAR_SQUOTE);
        add_row(CHAR_SQUOTE);
        add_row(CHAR_LF, 1'b1, 1'b0, 0, 0, 1'b1, 1'b0, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);

        repeat (RANDOM_CHARS)
            send_char(pick_char(), 1'b0, '0);

        send_idle_pct = 47;
        recv_idle_pct = 19;
        repeat (RANDOM_CHARS)
            send_char(pick_char(), 1'b0, '0);

        // No idling on either side: more random text.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_CHARS)
            send_char(pick_char(), 1'b0, '0);

        chars_if.valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters with %0d line ends; checked %0d result items, %0d spans.",
                 chars_sent, lines_sent, results_checked, spans_checked);
        $display("Covered the directed table and random text under three idling patterns.");
        if (fail_count == 0 && expected_spans.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
